### rtl/gn2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gn2d_pkg: shared types and constants for the 2D gradient noise block
// Holds the corner hash constants, the gradient select codes and the
// pipeline depth seen at the top level.
// ----------------------------------------------------------------------------
package gn2d_pkg;

	// corner hash: h = (cx*MX + cy*MY) * MUL, folded by h ^ (h >> 16)
	localparam logic [31:0] HASH_MX  = 32'd1619;
	localparam logic [31:0] HASH_MY  = 32'd31337;
	localparam logic [31:0] HASH_MUL = 32'h045d9f3b;

	// neighbor corners differ by a constant before the multiply, so their
	// hashes differ by that constant times MUL (mod 2^32)
	localparam logic [31:0] HASH_DX  = 32'(64'd1619 * 64'h045d9f3b);
	localparam logic [31:0] HASH_DY  = 32'(64'd31337 * 64'h045d9f3b);
	localparam logic [31:0] HASH_DXY = 32'(64'd32956 * 64'h045d9f3b);

	// register stages between an accepted sample and the edge that takes its result
	localparam int PIPE_DEPTH = 6;

	// axis gradient picked by the low two bits of the folded hash
	typedef enum logic [1:0] {
		GRAD_POS_X = 2'd0,
		GRAD_NEG_X = 2'd1,
		GRAD_POS_Y = 2'd2,
		GRAD_NEG_Y = 2'd3
	} grad_sel_t;

	// low two bits of h ^ (h >> 16)
	function automatic grad_sel_t fold_sel(input logic [31:0] h);
		return grad_sel_t'(h[1:0] ^ h[17:16]);
	endfunction

endpackage
`default_nettype wire

### rtl/gn2d_fade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gn2d_fade: quintic fade curve, three register stages
// fade(t) = t^3 * (t*(6t - 15) + 10), each product floored to FRAC_BITS.
// ----------------------------------------------------------------------------
module gn2d_fade #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic [FRAC_BITS-1:0] t,
	output logic      [FRAC_BITS-1:0] fade
);
	localparam int LW = FRAC_BITS + 6;          // 6t - 15, signed
	localparam int PW = FRAC_BITS + 1 + LW;     // t * (6t - 15)
	localparam int IW = FRAC_BITS + 4;          // inner term, in [1, 10]
	localparam logic signed [LW-1:0] C15 = LW'(15) << FRAC_BITS;
	localparam logic signed [LW-1:0] C10 = LW'(10) << FRAC_BITS;

	logic signed [LW-1:0]        lin;
	logic signed [PW-1:0]        prod_in;
	logic signed [LW-1:0]        inner;
	logic [2*FRAC_BITS-1:0]      sq;
	logic [FRAC_BITS-1:0]        t_s1;
	logic [FRAC_BITS-1:0]        tt_s1;
	logic [IW-1:0]               inner_s1;
	logic [2*FRAC_BITS-1:0]      cube;
	logic [FRAC_BITS-1:0]        t3_s2;
	logic [IW-1:0]               inner_s2;
	logic [2*FRAC_BITS+IW-1:0]   prod_out;
	logic [FRAC_BITS-1:0]        fade_s3;

	// stage 1: t^2 and the inner polynomial
	assign lin     = $signed(LW'({t, 2'b00}) + LW'({t, 1'b0})) - C15;
	assign prod_in = $signed({1'b0, t}) * lin;
	assign inner   = LW'(prod_in >>> FRAC_BITS) + C10;
	assign sq      = t * t;

	always_ff @(posedge clk) begin
		t_s1     <= t;
		tt_s1    <= sq[2*FRAC_BITS-1:FRAC_BITS];
		inner_s1 <= inner[IW-1:0];
	end

	// stage 2: t^3
	assign cube = tt_s1 * t_s1;

	always_ff @(posedge clk) begin
		t3_s2    <= cube[2*FRAC_BITS-1:FRAC_BITS];
		inner_s2 <= inner_s1;
	end

	// stage 3: t^3 * inner, stays below one
	assign prod_out = t3_s2 * inner_s2;

	always_ff @(posedge clk) begin
		fade_s3 <= prod_out[2*FRAC_BITS-1:FRAC_BITS];
	end

	assign fade = fade_s3;

endmodule
`default_nettype wire

### rtl/gn2d_corner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gn2d_corner: lattice cell, corner hashes and gradient dots
// Three register stages: hash pre-sum, hash multiply, fold and dot.
// ----------------------------------------------------------------------------
module gn2d_corner
	import gn2d_pkg::*;
#(
	parameter int FRAC_BITS    = 16,
	parameter int LATTICE_BITS = 8
) (
	input  wire logic                      clk,
	input  wire logic signed [31:0]        x_coord,
	input  wire logic signed [31:0]        y_coord,
	output logic signed [FRAC_BITS+1:0]    dot00,
	output logic signed [FRAC_BITS+1:0]    dot10,
	output logic signed [FRAC_BITS+1:0]    dot01,
	output logic signed [FRAC_BITS+1:0]    dot11
);
	localparam int DW = FRAC_BITS + 2;
	localparam logic signed [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;

	logic [47:0]             x_ext;
	logic [47:0]             y_ext;
	logic [LATTICE_BITS-1:0] ix;
	logic [LATTICE_BITS-1:0] iy;
	logic [31:0]             base_s1;
	logic [FRAC_BITS-1:0]    fx_s1;
	logic [FRAC_BITS-1:0]    fy_s1;
	logic [31:0]             hash_s2;
	logic [FRAC_BITS-1:0]    fx_s2;
	logic [FRAC_BITS-1:0]    fy_s2;
	logic signed [DW-1:0]    dx0;
	logic signed [DW-1:0]    dx1;
	logic signed [DW-1:0]    dy0;
	logic signed [DW-1:0]    dy1;
	logic signed [DW-1:0]    dot00_s3;
	logic signed [DW-1:0]    dot10_s3;
	logic signed [DW-1:0]    dot01_s3;
	logic signed [DW-1:0]    dot11_s3;

	// axis gradient dotted with the corner offset
	function automatic logic signed [DW-1:0] grad_dot(
		input logic [31:0]          h,
		input logic signed [DW-1:0] dx,
		input logic signed [DW-1:0] dy
	);
		logic signed [DW-1:0] res;
		case (fold_sel(h))
			GRAD_POS_X: res = dx;
			GRAD_NEG_X: res = -dx;
			GRAD_POS_Y: res = dy;
			GRAD_NEG_Y: res = -dy;
			default:    res = dx;
		endcase
		return res;
	endfunction

	// stage 1: floor cell, wrapped; hash pre-sum of the low corner
	assign x_ext = {{16{x_coord[31]}}, x_coord};
	assign y_ext = {{16{y_coord[31]}}, y_coord};
	assign ix    = x_ext[FRAC_BITS +: LATTICE_BITS];
	assign iy    = y_ext[FRAC_BITS +: LATTICE_BITS];

	always_ff @(posedge clk) begin
		base_s1 <= 32'(ix) * HASH_MX + 32'(iy) * HASH_MY;
		fx_s1   <= x_coord[FRAC_BITS-1:0];
		fy_s1   <= y_coord[FRAC_BITS-1:0];
	end

	// stage 2: one wrapping multiply serves all four corners
	always_ff @(posedge clk) begin
		hash_s2 <= base_s1 * HASH_MUL;
		fx_s2   <= fx_s1;
		fy_s2   <= fy_s1;
	end

	// stage 3: corner offsets, fold, gradient dot
	assign dx0 = $signed({2'b00, fx_s2});
	assign dy0 = $signed({2'b00, fy_s2});
	assign dx1 = dx0 - ONE_D;
	assign dy1 = dy0 - ONE_D;

	always_ff @(posedge clk) begin
		dot00_s3 <= grad_dot(hash_s2, dx0, dy0);
		dot10_s3 <= grad_dot(hash_s2 + HASH_DX, dx1, dy0);
		dot01_s3 <= grad_dot(hash_s2 + HASH_DY, dx0, dy1);
		dot11_s3 <= grad_dot(hash_s2 + HASH_DXY, dx1, dy1);
	end

	assign dot00 = dot00_s3;
	assign dot10 = dot10_s3;
	assign dot01 = dot01_s3;
	assign dot11 = dot11_s3;

endmodule
`default_nettype wire

### rtl/gradient_noise_2d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_2d: 2D gradient noise, one sample per clock
//
//   port group   dir   beat marked by      payload
//   sample       in    start & !busy       x_coord, y_coord (signed fixed)
//   result       out   done (one cycle)    noise_value (unsigned Q0.16)
//
// One sample per clock; the result strobe comes from valid_s6, the last of the
// valid registers. The pipeline depth is set by the fade curve's three chained
// multiplies followed by the two blend multiplies and the output stage.
// Reset clears only the valid bits; the data path needs none.
// busy is held low: the pipeline never stalls and the receiver cannot
// hold results off.
// ----------------------------------------------------------------------------
module gradient_noise_2d
	import gn2d_pkg::*;
#(
	parameter int FRAC_BITS    = 16,
	parameter int LATTICE_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] x_coord,
	input  wire logic signed [31:0] y_coord,
	output logic                    done,
	output logic [15:0]             noise_value
);
	localparam int DW = FRAC_BITS + 2;   // corner dot
	localparam int NW = FRAC_BITS + 3;   // blended values
	localparam int LIM = (1 << FRAC_BITS) + 2;
	localparam logic signed [NW-1:0] ONE_R  = NW'(1) << FRAC_BITS;
	localparam logic signed [NW-1:0] HALF_R = NW'(1) << (FRAC_BITS - 1);

	logic                        valid_s1, valid_s2, valid_s3;
	logic                        valid_s4, valid_s5, valid_s6;
	logic signed [DW-1:0]        n00, n10, n01, n11;
	logic [FRAC_BITS-1:0]        fade_u, fade_v;
	logic signed [FRAC_BITS+2:0] d_x0, d_x1;
	logic signed [2*FRAC_BITS+3:0] p_x0, p_x1;
	logic signed [FRAC_BITS+3:0] s_x0, s_x1;
	logic signed [NW-1:0]        nx0_s4, nx1_s4;
	logic [FRAC_BITS-1:0]        v_s4;
	logic signed [FRAC_BITS+3:0] d_y;
	logic signed [2*FRAC_BITS+4:0] p_y;
	logic signed [FRAC_BITS+4:0] s_y;
	logic signed [NW-1:0]        r_s5;
	logic signed [NW-1:0]        val;
	logic [FRAC_BITS+15:0]       val_ext;
	logic [15:0]                 q;
	logic [15:0]                 noise_s6;

	assign busy = 1'b0;

	// valid bits travel alongside the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stages 1-3: corner dots and fade curves
	gn2d_corner #(
		.FRAC_BITS    (FRAC_BITS),
		.LATTICE_BITS (LATTICE_BITS)
	) u_corner (
		.clk     (clk),
		.x_coord (x_coord),
		.y_coord (y_coord),
		.dot00   (n00),
		.dot10   (n10),
		.dot01   (n01),
		.dot11   (n11)
	);

	gn2d_fade #(
		.FRAC_BITS (FRAC_BITS)
	) u_fade_x (
		.clk  (clk),
		.t    (x_coord[FRAC_BITS-1:0]),
		.fade (fade_u)
	);

	gn2d_fade #(
		.FRAC_BITS (FRAC_BITS)
	) u_fade_y (
		.clk  (clk),
		.t    (y_coord[FRAC_BITS-1:0]),
		.fade (fade_v)
	);

	// stage 4: blend along x
	assign d_x0 = $signed({n10[DW-1], n10}) - $signed({n00[DW-1], n00});
	assign d_x1 = $signed({n11[DW-1], n11}) - $signed({n01[DW-1], n01});
	assign p_x0 = d_x0 * $signed({1'b0, fade_u});
	assign p_x1 = d_x1 * $signed({1'b0, fade_u});
	assign s_x0 = $signed({{2{n00[DW-1]}}, n00})
		+ $signed(p_x0[2*FRAC_BITS+3:FRAC_BITS]);
	assign s_x1 = $signed({{2{n01[DW-1]}}, n01})
		+ $signed(p_x1[2*FRAC_BITS+3:FRAC_BITS]);

	always_ff @(posedge clk) begin
		nx0_s4 <= s_x0[NW-1:0];
		nx1_s4 <= s_x1[NW-1:0];
		v_s4   <= fade_v;
	end

	// stage 5: blend along y
	assign d_y = $signed({nx1_s4[NW-1], nx1_s4}) - $signed({nx0_s4[NW-1], nx0_s4});
	assign p_y = d_y * $signed({1'b0, v_s4});
	assign s_y = $signed({{2{nx0_s4[NW-1]}}, nx0_s4})
		+ $signed(p_y[2*FRAC_BITS+4:FRAC_BITS]);

	always_ff @(posedge clk) begin
		r_s5 <= s_y[NW-1:0];
	end

	// stage 6: halve, offset, saturate, rescale to Q0.16
	assign val     = (r_s5 >>> 1) + HALF_R;
	assign val_ext = {val[FRAC_BITS-1:0], 16'h0000};

	always_comb begin
		if (val < 0) begin
			q = '0;
		end else if (val >= ONE_R) begin
			q = 16'hFFFF;
		end else begin
			q = val_ext[FRAC_BITS+15:FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		noise_s6 <= q;
	end

	assign done        = valid_s6;
	assign noise_value = noise_s6;

	// every accepted beat is followed by a result strobe
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("accepted sample produced no result");

	// no result without an accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##PIPE_DEPTH !done)
		else $error("result strobe without an accepted sample");

	// x blends stay within one unit, plus two lsb, of zero
	a_nx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (nx0_s4 >= -LIM && nx0_s4 <= LIM
			&& nx1_s4 >= -LIM && nx1_s4 <= LIM))
		else $error("x blend out of range");

	// final blend stays within range before the output mapping
	a_r_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (r_s5 >= -LIM && r_s5 <= LIM))
		else $error("y blend out of range");

endmodule
`default_nettype wire

### tb/sv/gradient_noise_2d_tb.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_tb: self-checking bench for the 2D gradient noise block
// A queue of sample points feeds a falling-edge driver; an accept process
// computes the expected noise value for every beat taken, and a monitor
// compares each result strobe with the oldest pending value.
// ----------------------------------------------------------------------------
module gradient_noise_2d_tb
	import gn2d_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC;
	localparam int RAND_ITEMS = 1100;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               drain_first;
	} sample_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        noise;
	} noise_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] x_coord = '0;
	logic signed [31:0] y_coord = '0;
	logic busy;
	logic done;
	logic [15:0] noise_value;

	sample_t    sample_q[$];
	noise_exp_t noise_q[$];

	logic beat_taken = 1'b0;
	int   item_total = 0;
	int   beats_taken = 0;
	int   results_checked = 0;
	int   saturated_cnt = 0;
	int   drains_done = 0;
	int   fail_cnt = 0;
	int   cycle_cnt = 0;

	gradient_noise_2d u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.done        (done),
		.noise_value (noise_value)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// noise predictor
	// ------------------------------------------------------------------

	// product truncated toward minus infinity to FRAC fraction bits
	function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p >>> FRAC;
	endfunction

	// 6t^5 - 15t^4 + 10t^3, evaluated as t^3 * (t*(6t - 15) + 10)
	function automatic logic signed [63:0] quintic_fade(input logic signed [63:0] t);
		logic signed [63:0] inner;
		logic signed [63:0] t3;
		inner = fix_mul(t, 6 * t - 15 * ONE) + 10 * ONE;
		t3 = fix_mul(fix_mul(t, t), t);
		return fix_mul(t3, inner);
	endfunction

	// wrapping corner hash folded down to a gradient pick
	function automatic grad_sel_t corner_grad(input logic [31:0] cx, input logic [31:0] cy);
		logic [31:0] h;
		h = (cx * 32'd1619 + cy * 32'd31337) * 32'h045d9f3b;
		h = h ^ (h >> 16);
		return grad_sel_t'(h[1:0]);
	endfunction

	function automatic logic signed [63:0] grad_dot(input grad_sel_t g,
			input logic signed [63:0] dx, input logic signed [63:0] dy);
		case (g)
			GRAD_POS_X: return dx;
			GRAD_NEG_X: return -dx;
			GRAD_POS_Y: return dy;
			default:    return -dy;
		endcase
	endfunction

	function automatic logic [15:0] noise_at(input logic signed [31:0] x,
			input logic signed [31:0] y);
		logic [31:0] ix, iy;
		logic signed [63:0] fx, fy, u, v;
		logic signed [63:0] n00, n10, n01, n11, nx0, nx1, r, val;
		// lattice cell by floor, wrapped to 256; the +1 corner is not rewrapped
		ix = 32'(x >>> FRAC) & 32'hFF;
		iy = 32'(y >>> FRAC) & 32'hFF;
		fx = {48'd0, x[15:0]};
		fy = {48'd0, y[15:0]};
		u = quintic_fade(fx);
		v = quintic_fade(fy);
		n00 = grad_dot(corner_grad(ix, iy), fx, fy);
		n10 = grad_dot(corner_grad(ix + 1, iy), fx - ONE, fy);
		n01 = grad_dot(corner_grad(ix, iy + 1), fx, fy - ONE);
		n11 = grad_dot(corner_grad(ix + 1, iy + 1), fx - ONE, fy - ONE);
		nx0 = n00 + fix_mul(n10 - n00, u);
		nx1 = n01 + fix_mul(n11 - n01, u);
		r = nx0 + fix_mul(nx1 - nx0, v);
		val = (r >>> 1) + (ONE >>> 1);
		if (val < 0)
			return 16'd0;
		if (val >= ONE)
			return 16'hFFFF;
		return val[15:0];
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic add_sample(input logic [31:0] x, input logic [31:0] y,
			input logic drain_first);
		sample_t s;
		s.x = x;
		s.y = y;
		s.drain_first = drain_first;
		sample_q.push_back(s);
	endtask

	// coordinate mix: full random, cells near zero, edge fractions, wrap cells
	function automatic logic [31:0] pick_coord();
		logic [31:0] r0, r1;
		int          lat_idx;
		r0 = $urandom;
		r1 = $urandom;
		case ($urandom_range(0, 5))
			0, 1: return r0;
			2: begin
				lat_idx = int'($urandom_range(0, 8)) - 4;
				return {16'(lat_idx), r0[15:0]};
			end
			3: begin
				case ($urandom_range(0, 4))
					0: return {r0[31:16], 16'h0000};
					1: return {r0[31:16], 16'h0001};
					2: return {r0[31:16], 16'h7FFF};
					3: return {r0[31:16], 16'h8000};
					default: return {r0[31:16], 16'hFFFF};
				endcase
			end
			4: return {r1[7:0], 8'hFF, r0[15:0]};
			default: return {r1[7:0], 8'h00, r0[15:0]};
		endcase
	endfunction

	// sender idle rate by run phase: light, heavy, none
	function automatic int idle_pct();
		if (beats_taken < item_total / 3)
			return 23;
		if (beats_taken < (2 * item_total) / 3)
			return 63;
		return 0;
	endfunction

	// ------------------------------------------------------------------
	// driver: new beat presented at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic send_ok;
		send_ok = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			send_ok = sample_q.size() != 0;
			// marked beats wait for the pipe to empty
			if (send_ok && sample_q[0].drain_first && noise_q.size() != 0)
				send_ok = 1'b0;
			if (send_ok && $urandom_range(0, 99) < idle_pct())
				send_ok = 1'b0;
			if (send_ok) begin
				x_coord <= sample_q[0].x;
				y_coord <= sample_q[0].y;
			end
			start <= send_ok;
		end
	end

	// ------------------------------------------------------------------
	// accept: beat taken at the rising edge, expected value queued
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		noise_exp_t e;
		beat_taken = 1'b0;
		if (arst_n && start && !busy) begin
			beat_taken = 1'b1;
			e.x = x_coord;
			e.y = y_coord;
			e.noise = noise_at(x_coord, y_coord);
			noise_q.push_back(e);
			if (sample_q.size() != 0) begin
				if (sample_q[0].drain_first)
					drains_done++;
				void'(sample_q.pop_front());
			end
			beats_taken++;
		end
	end

	// ------------------------------------------------------------------
	// monitor: each strobe checked against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		noise_exp_t e;
		if (arst_n && done) begin
			if (noise_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected result, expected none, actual noise_value=%h",
					$time, noise_value);
			end else begin
				e = noise_q.pop_front();
				results_checked++;
				if (e.noise == 16'hFFFF)
					saturated_cnt++;
				if (noise_value !== e.noise) begin
					fail_cnt++;
					$display("%0t: noise_value mismatch x=%h y=%h expected=%h actual=%h",
						$time, e.x, e.y, e.noise, noise_value);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, noise_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence: directed points, random points, drain and verdict
	// ------------------------------------------------------------------
	initial begin
		// origin, coordinate extremes and sign flips
		add_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		add_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		add_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_sample(32'hFFFF_0000, 32'h0001_0000, 1'b0);
		// far corner of the wrapped lattice, hashed without a second wrap
		add_sample(32'h00FF_8000, 32'h00FF_FFFF, 1'b0);
		add_sample(32'h00FF_0000, 32'h0000_0001, 1'b0);
		add_sample(32'hFFFF_8000, 32'h00FF_4000, 1'b0);
		add_sample(32'h7FFF_C000, 32'hFFFF_C000, 1'b0);
		// fraction edges: zero, one lsb, half, just under one
		add_sample(32'h0003_0001, 32'h0005_FFFF, 1'b0);
		add_sample(32'h0003_8000, 32'h0005_8000, 1'b0);
		add_sample(32'h0012_7FFF, 32'h0034_0001, 1'b0);
		add_sample(32'hFFFE_FFFF, 32'hFFFD_0000, 1'b0);
		// sweep of cells spread across the lattice
		for (int i = 0; i < 10; i++)
			add_sample({8'h00, 8'(i * 29), 16'h4000}, {8'h00, 8'(i * 53 + 7), 16'hC000}, 1'b0);
		// random points; some beats first let the pipe empty
		for (int i = 0; i < RAND_ITEMS; i++)
			add_sample(pick_coord(), pick_coord(),
				(i == 0) || (i == RAND_ITEMS / 3) || (i == (2 * RAND_ITEMS) / 3));
		item_total = sample_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sample_q.size() != 0 || noise_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);

		$display("Covered %0d samples (%0d saturated results, %0d pipe drains) over %0d cycles",
			beats_taken, saturated_cnt, drains_done, cycle_cnt);
		$display("Checked %0d noise results, %0d failures", results_checked, fail_cnt);
		if (fail_cnt == 0 && noise_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/gn2d_pkg.sv
rtl/gn2d_fade.sv
rtl/gn2d_corner.sv
rtl/gradient_noise_2d.sv
tb/sv/gradient_noise_2d_tb.sv
